FILE: sv/salru_pkg.sv
// Shared types, sizes and helper functions for the set-associative tag store.
// Used by the front end, the request queue, the lookup back end and the top level.
package salru_pkg;

  localparam int NUM_SETS    = 16;
  localparam int NUM_WAYS    = 4;
  localparam int ADDR_BITS   = 16;
  localparam int ADDR_W      = 16;
  localparam int SET_W       = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int TAG_W       = ADDR_BITS - SET_W;
  localparam int WAY_W       = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int WAY_USED_W  = 2;
  localparam int CNT_W       = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SET_W-1:0] set_idx_t;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [WAY_W-1:0] way_t;
  typedef logic [CNT_W-1:0] count_t;

  // Recency order of one set: entry 0 is the oldest way.
  typedef logic [NUM_WAYS-1:0][WAY_W-1:0] order_t;

  typedef struct packed {
    set_idx_t set_idx;
    tag_t     tag;
  } lookup_req_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [QCNT_W-1:0] count;
  } queue_stat_t;

  function automatic order_t order_reset();
    order_t o;
    for (int w = 0; w < NUM_WAYS; w++) begin
      o[w] = WAY_W'(w);
    end
    return o;
  endfunction

  // Moves the way at position pos to the newest slot, shifting younger ways down.
  function automatic order_t make_newest(order_t o, way_t pos);
    order_t r;
    r = o;
    for (int i = 0; i < NUM_WAYS - 1; i++) begin
      if (WAY_W'(i) >= pos) begin
        r[i] = o[i + 1];
      end
    end
    r[NUM_WAYS-1] = o[pos];
    return r;
  endfunction

endpackage

FILE: sv/salru_front.sv
// Front end: accepts block addresses and splits them into set index and tag.
// Depends on salru_pkg; feeds salru_queue.
module salru_front import salru_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ADDR_W-1:0] block_address,
  output logic              req_valid,
  output lookup_req_t       req,
  input  logic              req_full
);

  logic        held;
  lookup_req_t held_req;
  logic        accept;
  logic        push;

  assign in_stall  = held && req_full;
  assign accept    = in_valid && !in_stall;
  assign push      = held && !req_full;
  assign req_valid = held;
  assign req       = held_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
  end

  // Address bits above ADDR_BITS are dropped here.
  always_ff @(posedge clk) begin
    if (accept) begin
      held_req.set_idx <= block_address[SET_W-1:0];
      held_req.tag     <= block_address[ADDR_BITS-1:SET_W];
    end
  end

endmodule

FILE: sv/salru_queue.sv
// Short FIFO of lookup requests between the front end and the back end.
// Depends on salru_pkg.
module salru_queue import salru_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  input  lookup_req_t push_data,
  output logic        full,
  output logic        pop_valid,
  output lookup_req_t pop_data,
  input  logic        pop,
  output queue_stat_t stat
);

  lookup_req_t       entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  assign stat.push  = do_push;
  assign stat.pop   = do_pop;
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

FILE: sv/salru_back.sv
// Back end: tag compare, LRU update, refill on miss, counters and result register.
// Depends on salru_pkg; drains salru_queue.
module salru_back import salru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  lookup_req_t           req,
  output logic                  req_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_hit,
  output logic [WAY_USED_W-1:0] way_used,
  output count_t                hit_total,
  output count_t                miss_total
);

  logic [NUM_SETS-1:0][NUM_WAYS-1:0] valid_bits;
  logic [NUM_WAYS-1:0][TAG_W-1:0]    tag_store [NUM_SETS];
  order_t                            recency_order [NUM_SETS];
  count_t                            hit_counter;
  count_t                            miss_counter;

  logic   hit;
  way_t   way_sel;
  way_t   hit_pos;
  way_t   upd_pos;
  order_t cur_order;
  order_t order_next;

  assign req_pop    = req_valid && (!out_valid || !out_stall);
  assign hit_total  = hit_counter;
  assign miss_total = miss_counter;

  always_comb begin
    logic pos_found;
    pos_found = 1'b0;
    hit       = 1'b0;
    way_sel   = '0;
    hit_pos   = '0;
    cur_order = recency_order[req.set_idx];
    // Lowest matching valid way wins.
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!hit && valid_bits[req.set_idx][w] && tag_store[req.set_idx][w] == req.tag) begin
        hit     = 1'b1;
        way_sel = WAY_W'(w);
      end
    end
    for (int p = 0; p < NUM_WAYS; p++) begin
      if (!pos_found && cur_order[p] == way_sel) begin
        pos_found = 1'b1;
        hit_pos   = WAY_W'(p);
      end
    end
    if (!hit) begin
      way_sel = cur_order[0];
    end
    upd_pos    = hit ? hit_pos : '0;
    order_next = make_newest(cur_order, upd_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      valid_bits   <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        recency_order[s] <= order_reset();
      end
    end else begin
      if (req_pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (req_pop) begin
        recency_order[req.set_idx] <= order_next;
        if (hit) begin
          if (hit_counter != '1) begin
            hit_counter <= hit_counter + 1'b1;
          end
        end else begin
          valid_bits[req.set_idx][way_sel] <= 1'b1;
          if (miss_counter != '1) begin
            miss_counter <= miss_counter + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      is_hit   <= hit;
      way_used <= WAY_USED_W'(way_sel);
      if (!hit) begin
        tag_store[req.set_idx][way_sel] <= req.tag;
      end
    end
  end

endmodule

FILE: sv/set_assoc_cache_lru_tags.sv
// Set-associative tag store with LRU replacement: 16 sets, 4 ways, 12-bit tags.
// A transaction passes through the front-end hold register, the request queue and the back-end result register.
// Throughput: one transaction per cycle while out_stall does not hold the back end, set by the lookup in the back end.
// No set-to-set hazard exists because lookup and update finish in the same back-end cycle.
// Synchronous active-high reset clears valid bits, counters, queue and LRU order at once;
// no clearing pass is needed and transactions are accepted in the first cycle after reset.
module set_assoc_cache_lru_tags import salru_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [ADDR_W-1:0]     block_address,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_hit,
  output logic [WAY_USED_W-1:0] way_used,
  output count_t                hit_total,
  output count_t                miss_total
);

  // Front end to queue.
  logic        fq_valid;
  lookup_req_t fq_req;
  logic        fq_full;

  // Queue to back end.
  logic        qb_valid;
  lookup_req_t qb_req;
  logic        qb_pop;
  queue_stat_t q_stat;

  // The front end holds one address and splits it into set and tag. It only
  // stalls the input when it holds a transaction the queue cannot take.
  salru_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .block_address (block_address),
    .req_valid     (fq_valid),
    .req           (fq_req),
    .req_full      (fq_full)
  );

  // The queue absorbs output back-pressure so the front end keeps accepting
  // after the consumer stops, until the queue's two entries are full.
  salru_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_data  (fq_req),
    .full       (fq_full),
    .pop_valid  (qb_valid),
    .pop_data   (qb_req),
    .pop        (qb_pop),
    .stat       (q_stat)
  );

  // The back end compares all ways in parallel, updates recency and refills
  // on a miss, all in the cycle it loads the result register.
  salru_back u_back (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (qb_valid),
    .req        (qb_req),
    .req_pop    (qb_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_hit     (is_hit),
    .way_used   (way_used),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

`ifndef ASSERT_OFF
  // A reported hit implies a nonzero running hit total.
  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_hit |-> hit_total != '0)
    else $error("hit reported with zero hit total");

  // A reported miss implies a nonzero running miss total.
  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_hit |-> miss_total != '0)
    else $error("miss reported with zero miss total");

  // The queue never holds more than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("request queue overflow");

  // A pop without a push leaves one fewer entry in the queue.
  a_queue_pop: assert property (@(posedge clk) disable iff (rst)
    q_stat.pop && !q_stat.push |=> q_stat.count == $past(q_stat.count) - 1'b1)
    else $error("request queue count out of step with pops");
`endif

endmodule
